// ----- rtl/bsoc_pkg.sv -----
// Shared types, constants and helpers for the battery state-of-charge smoother.
package bsoc_pkg;

  localparam int unsigned SocW   = 8;
  localparam int unsigned CapW   = 7;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned RunW   = 3;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [SocW-1:0]  SOC_MAX       = 8'd100;
  localparam logic [SocW-1:0]  CHG_FULL_MIN  = 8'd95;
  localparam logic [SocW-1:0]  DIS_FULL_MIN  = 8'd90;
  localparam logic [SocW-1:0]  NEAR_FULL     = 8'd99;
  localparam logic [SocW-1:0]  LOW_SNAP_MAX  = 8'd2;
  localparam logic [RunW-1:0]  RUN_LIMIT     = 3'd5;
  localparam logic [RunW-1:0]  RUN_MAX       = 3'd7;
  localparam logic [HoldW-1:0] HOLD_MAX      = 16'hFFFF;

  localparam logic [HoldW-1:0] UP_HOLD_RST   = 16'd420;
  localparam logic [HoldW-1:0] DOWN_HOLD_RST = 16'd60;
  localparam logic [HoldW-1:0] ZERO_HOLD_RST = 16'd1800;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_UP_HOLD   = 2'd0;
  localparam logic [1:0] REG_DOWN_HOLD = 2'd1;
  localparam logic [1:0] REG_ZERO_HOLD = 2'd2;

  typedef struct packed {
    logic [HoldW-1:0] up_hold;
    logic [HoldW-1:0] down_hold;
    logic [HoldW-1:0] zero_hold;
  } cfg_t;

  typedef struct packed {
    logic [CapW-1:0] capacity_percent;
    logic            reading_valid;
    logic            reset_request;
  } res_t;

  function automatic logic [HoldW-1:0] sat_inc16(input logic [HoldW-1:0] v);
    sat_inc16 = (v == HOLD_MAX) ? HOLD_MAX : v + 16'd1;
  endfunction

endpackage

// ----- rtl/bsoc_cfg_regs.sv -----
// Configuration register file with APB-style access.
module bsoc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bsoc_pkg::AddrW-1:0] paddr,
  input  logic [bsoc_pkg::DataW-1:0] pwdata,
  output logic [bsoc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output bsoc_pkg::cfg_t            cfg
);
  import bsoc_pkg::*;

  logic [HoldW-1:0] up_hold_r;
  logic [HoldW-1:0] down_hold_r;
  logic [HoldW-1:0] zero_hold_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_hold_r   <= UP_HOLD_RST;
      down_hold_r <= DOWN_HOLD_RST;
      zero_hold_r <= ZERO_HOLD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_UP_HOLD:   up_hold_r   <= pwdata[HoldW-1:0];
        REG_DOWN_HOLD: down_hold_r <= pwdata[HoldW-1:0];
        REG_ZERO_HOLD: zero_hold_r <= pwdata[HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_UP_HOLD:   prdata = {{(DataW-HoldW){1'b0}}, up_hold_r};
      REG_DOWN_HOLD: prdata = {{(DataW-HoldW){1'b0}}, down_hold_r};
      REG_ZERO_HOLD: prdata = {{(DataW-HoldW){1'b0}}, zero_hold_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.up_hold   = up_hold_r;
  assign cfg.down_hold = down_hold_r;
  assign cfg.zero_hold = zero_hold_r;

endmodule

// ----- rtl/bsoc_filter.sv -----
// Smoothing state and single-pass update logic for one reading.
module bsoc_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [bsoc_pkg::SocW-1:0]  soc_reading,
  input  logic                       charger_online,
  input  bsoc_pkg::cfg_t             cfg,
  output bsoc_pkg::res_t             res
);
  import bsoc_pkg::*;

  logic [CapW-1:0]  cap_r,  cap_nxt;
  logic [RunW-1:0]  run_r,  run_nxt;
  logic [HoldW-1:0] fh_r,   fh_nxt;
  logic             ff_r,   ff_nxt;
  logic [HoldW-1:0] zc_r,   zc_nxt;
  logic             qd_r,   qd_nxt;

  logic [SocW-1:0]  cap8;
  logic [SocW-1:0]  v;
  logic [SocW-1:0]  lower;
  logic [RunW-1:0]  run_inc;
  logic [HoldW-1:0] fh_inc;
  logic [HoldW-1:0] zc_inc;
  logic             chg;
  logic             req;
  logic             against;
  logic             snap_ok;

  always_comb begin
    chg     = charger_online;
    cap8    = {1'b0, cap_r};
    run_inc = (run_r >= RUN_MAX) ? RUN_MAX : run_r + 3'd1;
    fh_inc  = sat_inc16(fh_r);
    zc_inc  = sat_inc16(zc_r);
    lower   = cap8 - 8'd1;
    v       = soc_reading;
    req     = 1'b0;
    against = 1'b0;
    snap_ok = 1'b0;
    cap_nxt = cap_r;
    run_nxt = run_r;
    fh_nxt  = fh_r;
    ff_nxt  = ff_r;
    zc_nxt  = zc_r;
    qd_nxt  = qd_r;

    if (soc_reading > SOC_MAX) begin
      // hold capacity, count the bad run
      run_nxt = run_inc;
      if (run_inc > RUN_LIMIT) begin
        req     = 1'b1;
        run_nxt = '0;
      end
      res.capacity_percent = cap_r;
      res.reading_valid    = 1'b0;
    end else begin
      run_nxt = '0;

      against = (chg && cap_r != '0 && v == cap8 - 8'd1) || (!chg && v == cap8 + 8'd1);
      snap_ok = (v == '0 && cap8 <= LOW_SNAP_MAX) || (v == SOC_MAX && cap8 == NEAR_FULL);
      if (against && !snap_ok) begin
        v = cap8;
      end

      if (chg && v >= CHG_FULL_MIN && v <= cap8) begin
        fh_nxt = fh_inc;
        if (fh_inc >= cfg.up_hold) begin
          v      = (cap8 + 8'd1 <= SOC_MAX) ? cap8 + 8'd1 : SOC_MAX;
          ff_nxt = 1'b1;
          fh_nxt = '0;
        end else begin
          v = cap8;
        end
      end else if (!chg && v <= cap8 && v >= DIS_FULL_MIN && ff_r) begin
        fh_nxt = fh_inc;
        if (fh_inc >= cfg.down_hold) begin
          fh_nxt = '0;
          if (v >= lower) begin
            ff_nxt = 1'b0;
          end else begin
            v = lower;
          end
        end else begin
          v = cap8;
        end
      end else begin
        fh_nxt = '0;
      end

      if (chg && v == '0) begin
        zc_nxt = zc_inc;
        if (zc_inc >= cfg.zero_hold && !qd_r) begin
          req    = 1'b1;
          qd_nxt = 1'b1;
          zc_nxt = '0;
        end
      end else if (qd_r && !chg) begin
        qd_nxt = 1'b0;
      end

      cap_nxt              = v[CapW-1:0];
      res.capacity_percent = v[CapW-1:0];
      res.reading_valid    = 1'b1;
    end
    res.reset_request = req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
      run_r <= '0;
      fh_r  <= '0;
      ff_r  <= 1'b0;
      zc_r  <= '0;
      qd_r  <= 1'b0;
    end else if (step_en) begin
      cap_r <= cap_nxt;
      run_r <= run_nxt;
      fh_r  <= fh_nxt;
      ff_r  <= ff_nxt;
      zc_r  <= zc_nxt;
      qd_r  <= qd_nxt;
    end
  end

endmodule

// ----- rtl/battery_soc_smoother.sv -----
// A word enters the input register, passes the filter and lands in the result
// register behind out_valid. Throughput: one word per cycle while out_stall is low;
// both registers let a new word enter while the previous result waits on out_stall.
// The filter state updates in the single step between the two registers.
// Reset (rst_n low, synchronous) empties both registers, clears filter state
// and loads the hold-count registers with 420, 60 and 1800.
module battery_soc_smoother (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bsoc_pkg::SocW-1:0]   in_soc_reading,
  input  logic                        in_charger_online,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bsoc_pkg::CapW-1:0]   out_capacity_percent,
  output logic                        out_reading_valid,
  output logic                        out_reset_request,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsoc_pkg::AddrW-1:0]  paddr,
  input  logic [bsoc_pkg::DataW-1:0]  pwdata,
  output logic [bsoc_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import bsoc_pkg::*;

  cfg_t            cfg;
  res_t            res;
  res_t            res_r;
  logic            s1_valid_r;
  logic [SocW-1:0] s1_soc_r;
  logic            s1_chg_r;
  logic            out_valid_r;
  logic            out_free;
  logic            step_en;
  logic            in_acc;

  bsoc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsoc_filter u_filter (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .soc_reading    (s1_soc_r),
    .charger_online (s1_chg_r),
    .cfg            (cfg),
    .res            (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (step_en) begin
        s1_valid_r <= 1'b0;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: load on accept / step only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_soc_r <= in_soc_reading;
      s1_chg_r <= in_charger_online;
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_capacity_percent = res_r.capacity_percent;
  assign out_reading_valid    = res_r.reading_valid;
  assign out_reset_request    = res_r.reset_request;

endmodule

// ----- rtl/bsoc_checker.sv -----
// Port-level checker for the smoother and its bind to the top level.
module bsoc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [bsoc_pkg::CapW-1:0] out_capacity_percent,
  input logic                      out_reading_valid,
  input logic                      out_reset_request
);
  import bsoc_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // input backs up only when a result is waiting on a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_capacity_percent} <= SOC_MAX)
    else $error("capacity above full scale");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_capacity_percent)
      && $stable(out_reading_valid) && $stable(out_reset_request))
    else $error("stalled result changed");

endmodule

bind battery_soc_smoother bsoc_checker u_bsoc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_capacity_percent (out_capacity_percent),
  .out_reading_valid    (out_reading_valid),
  .out_reset_request    (out_reset_request)
);
